// File: sv/sorted_table_insert_delete_search_assert.svh
// Assertion macros for the sorted table checker.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef SORTED_TABLE_INSERT_DELETE_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_DELETE_SEARCH_ASSERT_SVH

// checked only out of reset
`define STIDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STIDS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/stids_pkg.sv
// Shared codes for the sorted table block.
// Depends on nothing.
`timescale 1ns / 1ps

package stids_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [2:0] status_t;

	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_DELETE = 2'd1;
	localparam mode_t MODE_SEARCH = 2'd2;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_BADPOS   = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;

endpackage

// File: sv/sorted_table_insert_delete_search.sv
// Sorted table: insert in order, delete by position, search by key. Depends on stids_pkg.
// Rejected and no-op items finish straight from idle; insert walks down moving larger entries up,
// delete shifts the later entries down, search walks up until a match or the end of the table.
// A new item is taken only while idle, so each item is finished before the next; rejected items
// go back to back. Limit: the walk through the entry RAM, one read and one write per cycle.
// arst_n clears the entry count, state and result registers; RAM contents are not cleared.
`timescale 1ns / 1ps

module sorted_table_insert_delete_search #(
	parameter int CAPACITY = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic signed [31:0]     value,
	input  logic [3:0]             position,
	output logic                   done,
	output logic [2:0]             status,
	output logic signed [31:0]     result_value,
	output logic [3:0]             result_index,
	output logic [4:0]             entry_count
);

	// IW addresses the RAM, CW holds 0..CAPACITY
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int NW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_LAST,
		S_DEL_VAL,
		S_DEL_SH,
		S_SRCH_CMP
	} state_t;

	state_t state_q;

	// entry RAM: one write port, one registered read port
	logic signed [31:0] entries_q [CAPACITY];
	logic signed [31:0] rd_q;
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	logic [IW-1:0]      mem_ra;
	logic signed [31:0] mem_wd;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      i_q;
	logic signed [31:0] val_q;
	logic               done_q;
	stids_pkg::status_t status_q;
	logic signed [31:0] rval_q;
	logic [IW-1:0]      ridx_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] im1;
	logic [CW-1:0] im2;
	logic [CW-1:0] ip1;
	logic [CW-1:0] ip2;
	logic [PW-1:0] pos_x;
	logic          greater;
	logic          accept;

	assign accept  = start && (state_q == S_IDLE);
	assign cnt_m1  = count_q - CW'(1);
	assign im1     = i_q - CW'(1);
	assign im2     = i_q - CW'(2);
	assign ip1     = i_q + CW'(1);
	assign ip2     = i_q + CW'(2);
	assign pos_x   = PW'(position);
	// the shared compare: stored entry against the item's value
	assign greater = rd_q > val_q;

	// RAM address and write control from the sequencer
	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_q[IW-1:0];
		mem_wd = rd_q;
		mem_ra = '0;
		case (state_q)
			S_IDLE: begin
				// first read goes out with the accept
				case (mode)
					stids_pkg::MODE_INSERT: mem_ra = cnt_m1[IW-1:0];
					stids_pkg::MODE_DELETE: mem_ra = pos_x[IW-1:0];
					default:                mem_ra = '0;
				endcase
			end
			S_INS_CMP: begin
				// walk down from the top: move larger entries up, else drop value in
				mem_ra = im2[IW-1:0];
				mem_we = 1'b1;
				mem_wd = greater ? rd_q : val_q;
			end
			S_INS_LAST: begin
				mem_we = 1'b1;
				mem_wd = val_q;
			end
			S_DEL_VAL: begin
				mem_ra = ip1[IW-1:0];
			end
			S_DEL_SH: begin
				// close the gap one slot per cycle
				mem_ra = ip2[IW-1:0];
				mem_we = 1'b1;
				mem_wd = rd_q;
			end
			S_SRCH_CMP: begin
				mem_ra = ip1[IW-1:0];
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_q[mem_wa] <= mem_wd;
		end
		rd_q <= entries_q[mem_ra];
	end

	// sequencer, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			i_q      <= '0;
			val_q    <= '0;
			status_q <= stids_pkg::ST_OK;
			rval_q   <= '0;
			ridx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q    <= value;
						rval_q   <= '0;
						ridx_q   <= '0;
						status_q <= stids_pkg::ST_OK;
						case (mode)
							stids_pkg::MODE_INSERT: begin
								if (count_q >= CW'(CAPACITY)) begin
									status_q <= stids_pkg::ST_FULL;
									done_q   <= 1'b1;
								end else if (count_q == '0) begin
									i_q     <= '0;
									state_q <= S_INS_LAST;
								end else begin
									i_q     <= count_q;
									state_q <= S_INS_CMP;
								end
							end
							stids_pkg::MODE_DELETE: begin
								if (count_q == '0) begin
									status_q <= stids_pkg::ST_EMPTY;
									done_q   <= 1'b1;
								end else if (pos_x >= PW'(count_q)) begin
									status_q <= stids_pkg::ST_BADPOS;
									done_q   <= 1'b1;
								end else begin
									i_q     <= pos_x[CW-1:0];
									state_q <= S_DEL_VAL;
								end
							end
							stids_pkg::MODE_SEARCH: begin
								rval_q <= value;
								i_q    <= '0;
								if (count_q == '0) begin
									status_q <= stids_pkg::ST_NOTFOUND;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SRCH_CMP;
								end
							end
							default: begin
								// unused mode: plain ok result
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_INS_CMP: begin
					if (greater) begin
						i_q <= im1;
						if (im1 == '0) begin
							state_q <= S_INS_LAST;
						end
					end else begin
						ridx_q  <= i_q[IW-1:0];
						count_q <= count_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INS_LAST: begin
					ridx_q  <= '0;
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEL_VAL: begin
					rval_q <= rd_q;
					ridx_q <= i_q[IW-1:0];
					if (ip1 < count_q) begin
						state_q <= S_DEL_SH;
					end else begin
						count_q <= cnt_m1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DEL_SH: begin
					i_q <= ip1;
					if (ip2 >= count_q) begin
						count_q <= cnt_m1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SRCH_CMP: begin
					if (rd_q == val_q) begin
						ridx_q  <= i_q[IW-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (ip1 < count_q) begin
						i_q <= ip1;
					end else begin
						status_q <= stids_pkg::ST_NOTFOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic [XW-1:0] ridx_x;
	logic [NW-1:0] cnt_x;

	assign ridx_x       = XW'(ridx_q);
	assign cnt_x        = NW'(count_q);
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign result_value = rval_q;
	assign result_index = ridx_x[3:0];
	assign entry_count  = cnt_x[4:0];

endmodule

// File: sv/stids_checker.sv
// Port-level checks for the sorted table block, bound to its top level.
// Depends on stids_pkg and sorted_table_insert_delete_search_assert.svh.
`timescale 1ns / 1ps
`include "sorted_table_insert_delete_search_assert.svh"

module stids_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [3:0]  result_index
);

	// a result always ends the work, so busy is already low with it
	`STIDS_ASSERT(a_done_idle, done |-> !busy, "done while busy")
	// an accepted item either finishes next cycle or keeps the block busy
	`STIDS_ASSERT(a_accept_next, (start && !busy) |=> (busy || done), "accepted item dropped")
	// the block only leaves work by delivering a result
	`STIDS_ASSERT(a_busy_end, $fell(busy) |-> done, "busy ended without result")
	// failed requests report no index
	`STIDS_ASSERT(a_fail_index, (done && status != stids_pkg::ST_OK) |-> (result_index == 4'd0), "index on failure")
	`STIDS_ASSERT_ALWAYS(a_reset, !arst_n |-> (!busy && !done), "not idle in reset")

endmodule

bind sorted_table_insert_delete_search stids_checker u_stids_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.result_index (result_index)
);

// File: test/sorted_table_insert_delete_search_tb.sv
// Self-checking bench for the sorted table: insert in order, delete by position, search by key.
// Needs stids_pkg and sorted_table_insert_delete_search; a class-based tracker predicts each result.
`timescale 1ns / 1ps

module sorted_table_insert_delete_search_tb;

	localparam int CAPACITY = 16;
	// mode 3 is not an operation; the block answers with an all-zero ok result
	localparam stids_pkg::mode_t MODE_NOOP = 2'd3;
	localparam int RANDOM_ITEMS = 1400;
	// worst case per item is a full walk of the table plus sender gaps; taken many times over
	localparam int CYCLE_LIMIT = 400000;
	// drain after the last result, comfortably past the longest walk of the table
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		stids_pkg::status_t status;
		logic signed [31:0] value;
		logic [3:0]         index;
		logic [4:0]         count;
	} outcome_t;

	// Shadow of the table: tracks the sorted contents and queues one outcome per item.
	class sorted_table_tracker;
		logic signed [31:0] slots[CAPACITY];
		int                 held;
		outcome_t           pending_outcomes[$];
		int                 errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function void note_request(stids_pkg::mode_t m, logic signed [31:0] v, logic [3:0] p);
			outcome_t o;
			int slot;
			int i;
			o.status = stids_pkg::ST_OK;
			o.value = '0;
			o.index = '0;
			case (m)
				stids_pkg::MODE_INSERT: begin
					if (held >= CAPACITY) begin
						o.status = stids_pkg::ST_FULL;
					end else begin
						// goes after every entry not greater than it
						slot = 0;
						while (slot < held && !(slots[slot] > v))
							slot++;
						for (i = held; i > slot; i--)
							slots[i] = slots[i - 1];
						slots[slot] = v;
						held++;
						o.index = slot[3:0];
					end
				end
				stids_pkg::MODE_DELETE: begin
					if (held == 0) begin
						o.status = stids_pkg::ST_EMPTY;
					end else if (int'(p) >= held) begin
						o.status = stids_pkg::ST_BADPOS;
					end else begin
						o.value = slots[p];
						for (i = int'(p); i + 1 < held; i++)
							slots[i] = slots[i + 1];
						held--;
						o.index = p;
					end
				end
				stids_pkg::MODE_SEARCH: begin
					o.value = v;
					o.status = stids_pkg::ST_NOTFOUND;
					for (i = 0; i < held; i++) begin
						if (slots[i] == v) begin
							o.status = stids_pkg::ST_OK;
							o.index = i[3:0];
							break;
						end
					end
				end
				default: begin
				end
			endcase
			o.count = held[4:0];
			pending_outcomes.push_back(o);
		endfunction

		function void check_response(stids_pkg::status_t s, logic signed [31:0] v,
				logic [3:0] idx, logic [4:0] n);
			outcome_t e;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with nothing outstanding: status %0d value %0d",
					$time, s, v);
				errors++;
				return;
			end
			e = pending_outcomes.pop_front();
			if (s !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, s);
				errors++;
			end
			if (v !== e.value) begin
				$display("%0t: result_value expected %0d actual %0d", $time, e.value, v);
				errors++;
			end
			if (idx !== e.index) begin
				$display("%0t: result_index expected %0d actual %0d", $time, e.index, idx);
				errors++;
			end
			if (n !== e.count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, e.count, n);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               start = 1'b0;
	logic               busy;
	stids_pkg::mode_t   mode = stids_pkg::MODE_INSERT;
	logic signed [31:0] value = '0;
	logic [3:0]         position = '0;
	logic               done;
	stids_pkg::status_t status;
	logic signed [31:0] result_value;
	logic [3:0]         result_index;
	logic [4:0]         entry_count;

	sorted_table_tracker table_model = new();
	int  cycles = 0;
	bit  no_gaps = 1'b0;   // set during the back-to-back stretch

	sorted_table_insert_delete_search #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.position(position),
		.done(done),
		.status(status),
		.result_value(result_value),
		.result_index(result_index),
		.entry_count(entry_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** sorted_table_insert_delete_search: FAILED **");
			$finish;
		end
	end

	// Results are one-cycle strobes; sampled at the edge that closes the cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			table_model.check_response(status, result_value, result_index, entry_count);
	end

	// One item: optional idle cycles, then start held until an edge sees busy low.
	// Every input change lands on a falling edge; an item's inputs all change at the same edge.
	task automatic send_request(input stids_pkg::mode_t m, input logic signed [31:0] v,
			input logic [3:0] p);
		while (!no_gaps && $urandom_range(99) < 22) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		value <= v;
		position <= p;
		do
			@(posedge clk);
		while (busy);
		// busy was low at this edge: item taken
		table_model.note_request(m, v, p);
	endtask

	// Operand mix: small values for duplicates and hits, the extremes, and raw 32-bit noise.
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $signed($urandom_range(15)) - 8;
		if (r < 55) begin
			case ($urandom_range(5))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				3: return 32'sh7fff_fffe;
				4: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom;
	endfunction

	task automatic run_random(input int n);
		int k;
		int r;
		bit filling;
		stids_pkg::mode_t m;
		logic signed [31:0] v;
		logic [3:0] p;
		filling = 1'b1;
		for (k = 0; k < n; k++) begin
			// back-to-back stretch in the middle of the run
			no_gaps = (k >= 500 && k < 850);
			// swing the fill level: grow to full, sit there, then drain to empty
			if (k % 45 == 0)
				filling = !filling;
			r = $urandom_range(99);
			if (filling)
				m = (r < 55) ? stids_pkg::MODE_INSERT : (r < 70) ? stids_pkg::MODE_DELETE :
					(r < 96) ? stids_pkg::MODE_SEARCH : MODE_NOOP;
			else
				m = (r < 15) ? stids_pkg::MODE_INSERT : (r < 70) ? stids_pkg::MODE_DELETE :
					(r < 96) ? stids_pkg::MODE_SEARCH : MODE_NOOP;
			v = pick_value();
			p = 4'($urandom_range(15));
			// searches aim at a stored key half the time, deletes at a live slot three times in four
			if (m == stids_pkg::MODE_SEARCH && table_model.held > 0 && $urandom_range(1))
				v = table_model.slots[$urandom_range(table_model.held - 1)];
			if (m == stids_pkg::MODE_DELETE && table_model.held > 0 && $urandom_range(3) != 0)
				p = 4'($urandom_range(table_model.held - 1));
			send_request(m, v, p);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		// reset goes low at time zero as a real edge
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, no-op, extremes, duplicates, hits and misses, bad positions
		send_request(stids_pkg::MODE_SEARCH, 32'sd5, 4'd0);
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd0);
		send_request(MODE_NOOP, 32'sh7fff_ffff, 4'd15);
		send_request(stids_pkg::MODE_INSERT, 32'sh7fff_ffff, 4'd0);
		send_request(stids_pkg::MODE_INSERT, 32'sh8000_0000, 4'd15);
		send_request(stids_pkg::MODE_INSERT, 32'sd0, 4'd0);
		send_request(stids_pkg::MODE_INSERT, -32'sd1, 4'd0);
		send_request(stids_pkg::MODE_INSERT, 32'sd0, 4'd0);          // after the equal entry
		send_request(stids_pkg::MODE_SEARCH, 32'sd0, 4'd0);          // first of the two zeros
		send_request(stids_pkg::MODE_SEARCH, 32'sh1234_5678, 4'd0);  // absent key
		send_request(stids_pkg::MODE_SEARCH, 32'sh8000_0000, 4'd0);
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd5);          // position equal to count
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd15);
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd4);          // last entry
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd0);          // first entry
		send_request(stids_pkg::MODE_INSERT, 32'sh7fff_ffff, 4'd0);
		send_request(stids_pkg::MODE_SEARCH, 32'sh7fff_ffff, 4'd0);
		send_request(stids_pkg::MODE_DELETE, 32'sd0, 4'd1);          // middle entry

		run_random(RANDOM_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (table_model.outstanding() != 0)
			@(posedge clk);
		// any stray strobe in this window is caught by the result monitor
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (table_model.errors == 0 && table_model.outstanding() == 0) begin
			$display("** sorted_table_insert_delete_search: PASSED **");
		end else begin
			$display("** sorted_table_insert_delete_search: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/stids_pkg.sv
sv/sorted_table_insert_delete_search.sv
sv/stids_checker.sv
test/sorted_table_insert_delete_search_tb.sv
